// ===== hdl/blecw_pkg.sv =====
`default_nettype none

package blecw_pkg;

	localparam int CrcWidth = 24;

	localparam logic [CrcWidth-1:0] CRC_POLY      = 24'h00065B;
	localparam logic [CrcWidth-1:0] CRC_START_RST = 24'h555555;
	localparam logic [7:0]          WHITEN_TAP    = 8'h11;
	localparam logic [7:0]          WHITEN_SEED   = 8'h02;
	localparam logic [1:0]          TAIL_BYTES    = 2'd3;

	typedef struct packed {
		logic [7:0] lfsr;
		logic [7:0] data;
	} whiten_res_t;

	function automatic logic [7:0] rev8(input logic [7:0] x);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = x[7-i];
		end
		return r;
	endfunction

	// The CRC register takes the data byte LSB first, eight shifts per call.
	function automatic logic [CrcWidth-1:0] crc_feed(input logic [CrcWidth-1:0] crc,
			input logic [7:0] d);
		logic [CrcWidth-1:0] c;
		logic                top;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			top = c[CrcWidth-1];
			c = {c[CrcWidth-2:0], 1'b0};
			if (top != d[i]) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic whiten_res_t whiten(input logic [7:0] lfsr, input logic [7:0] d);
		whiten_res_t res;
		res.lfsr = lfsr;
		res.data = d;
		for (int i = 0; i < 8; i++) begin
			if (res.lfsr[7]) begin
				res.lfsr = res.lfsr ^ WHITEN_TAP;
				res.data[i] = ~res.data[i];
			end
			res.lfsr = {res.lfsr[6:0], 1'b0};
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ble_packet_crc_whiten_encoder_top.sv =====
// BLE CRC-24 and data whitening encoder.
// The input stream carries the PDU bytes of one packet, header first; s_tlast
// marks the final PDU byte. The channel field is sampled on the first byte of
// each packet and seeds the whitening register; the CRC register is seeded
// from the configured start value at the same time.
// Every PDU byte yields one whitened, bit-reversed output item in the cycle after
// it is accepted. After the final PDU byte the three CRC bytes follow as output
// items with m_tuser high; m_tlast marks the third one.
// Throughput is one item per cycle inside a packet while the receiver is ready.
// After the last byte s_tready stays low until the third CRC byte is registered.
// A single output register sits between the sides: a new item is taken while
// the previous result is being consumed in the same cycle. When the receiver
// stalls, the output holds and s_tready drops.
// The configuration channel is always ready; a new start value takes effect at
// the first byte of the next packet. Reset sets the start value to 0x555555
// and leaves the block waiting for the first byte of a packet.
`default_nettype none

module ble_packet_crc_whiten_encoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [23:0] cfg_data,   // crc_start
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [15:0] s_tdata,    // data_byte [7:0], channel [13:8], zeros [15:14]
	input  wire logic        s_tlast,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [7:0]  m_tdata,    // out_byte [7:0]
	output      logic        m_tuser,    // is_crc [0]
	output      logic        m_tlast
);

	import blecw_pkg::*;

	logic [CrcWidth-1:0] crc_start_q;
	logic [CrcWidth-1:0] crc_q;
	logic [7:0]          whiten_q;
	logic                in_packet_q;
	logic [1:0]          tail_cnt_q;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                is_crc_q;
	logic                eop_q;

	logic                load_en;
	logic                s_acc;
	logic                tail_emit;
	logic [7:0]          data_byte;
	logic [5:0]          channel;
	logic [CrcWidth-1:0] crc_base;
	logic [7:0]          whiten_base;
	logic [CrcWidth-1:0] crc_next;
	whiten_res_t         data_wh;
	whiten_res_t         tail_wh;

	assign data_byte = s_tdata[7:0];
	assign channel   = s_tdata[13:8];

	assign cfg_ready = 1'b1;
	assign load_en   = !out_valid_q || m_tready;
	assign s_tready  = load_en && (tail_cnt_q == 2'd0);
	assign s_acc     = s_tvalid && s_tready;
	assign tail_emit = load_en && (tail_cnt_q != 2'd0);

	always_comb begin
		crc_base    = in_packet_q ? crc_q : crc_start_q;
		whiten_base = in_packet_q ? whiten_q : (rev8({2'b00, channel}) | WHITEN_SEED);
		crc_next    = crc_feed(crc_base, data_byte);
		data_wh     = whiten(whiten_base, data_byte);
		tail_wh     = whiten(whiten_q, rev8(crc_q[CrcWidth-1:CrcWidth-8]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_start_q <= CRC_START_RST;
		end else if (cfg_valid && cfg_ready) begin
			crc_start_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CRC_START_RST;
			whiten_q    <= '0;
			in_packet_q <= 1'b0;
			tail_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (s_acc) begin
			crc_q       <= crc_next;
			whiten_q    <= data_wh.lfsr;
			in_packet_q <= !s_tlast;
			tail_cnt_q  <= s_tlast ? TAIL_BYTES : 2'd0;
			out_valid_q <= 1'b1;
		end else if (tail_emit) begin
			crc_q       <= {crc_q[CrcWidth-9:0], 8'h00};
			whiten_q    <= tail_wh.lfsr;
			tail_cnt_q  <= tail_cnt_q - 2'd1;
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			out_byte_q <= rev8(data_wh.data);
			is_crc_q   <= 1'b0;
			eop_q      <= 1'b0;
		end else if (tail_emit) begin
			out_byte_q <= rev8(tail_wh.data);
			is_crc_q   <= 1'b1;
			eop_q      <= (tail_cnt_q == 2'd1);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = is_crc_q;
	assign m_tlast  = eop_q;

	a_acc_gives_data: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> m_tvalid && !m_tuser && !m_tlast)
		else $error("accepted byte did not produce a data output item");

	a_last_starts_tail: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tlast |=> (tail_cnt_q == TAIL_BYTES) && !in_packet_q)
		else $error("last byte did not start the CRC tail");

	a_tail_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_cnt_q != 2'd0) |-> !s_tready)
		else $error("input accepted during the CRC tail");

	a_tail_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser && !m_tlast |=> m_tvalid && m_tuser)
		else $error("CRC byte sequence was interrupted");

	a_eop_is_crc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser && (tail_cnt_q == 2'd0))
		else $error("end of packet on a non-final CRC byte");

endmodule

`default_nettype wire

// ===== sim/tb_ble_packet_crc_whiten_encoder_top.sv =====
`timescale 1ns / 100ps

module tb_ble_packet_crc_whiten_encoder_top;

	localparam logic [23:0] CRC24_FEEDBACK = 24'h00065B;
	localparam logic [23:0] CRC24_SEED_RST = 24'h555555;
	// The whitening tap, already shifted into place by one step.
	localparam logic [7:0]  WHITEN_STEP    = 8'h22;
	localparam logic [7:0]  WHITEN_ONE     = 8'h02;
	localparam int          HOLD_CYCLES    = 60;
	localparam int          PHASE_ITEMS    = 115;

	typedef struct packed {
		logic [7:0] out_val;
		logic       crc_flag;
		logic       eop;
	} air_byte_t;

	typedef struct packed {
		logic        cfg_before;
		logic [23:0] cfg_value;
		logic [7:0]  data;
		logic        last;
		logic [5:0]  chan;
		logic        pinned;
		logic [7:0]  pinned_out;
	} pdu_row_t;

	localparam int N_ROWS = 17;
	localparam pdu_row_t PDU_SCRIPT [N_ROWS] = '{
		'{1'b0, 24'h000000, 8'h00, 1'b0, 6'd0,  1'b1, 8'h02},
		'{1'b0, 24'h000000, 8'hFF, 1'b0, 6'd0,  1'b0, 8'h00},
		'{1'b0, 24'h000000, 8'hA5, 1'b1, 6'd0,  1'b0, 8'h00},
		'{1'b0, 24'h000000, 8'hFF, 1'b1, 6'd0,  1'b1, 8'hFD},
		'{1'b0, 24'h000000, 8'h00, 1'b1, 6'd39, 1'b0, 8'h00},
		'{1'b0, 24'h000000, 8'h5A, 1'b0, 6'd63, 1'b0, 8'h00},
		'{1'b0, 24'h000000, 8'h3C, 1'b0, 6'd0,  1'b0, 8'h00},
		'{1'b0, 24'h000000, 8'h81, 1'b1, 6'd21, 1'b0, 8'h00},
		'{1'b0, 24'h000000, 8'h12, 1'b0, 6'd40, 1'b0, 8'h00},
		'{1'b0, 24'h000000, 8'h34, 1'b1, 6'd37, 1'b0, 8'h00},
		'{1'b0, 24'h000000, 8'h01, 1'b0, 6'd38, 1'b0, 8'h00},
		'{1'b1, 24'h000000, 8'h02, 1'b1, 6'd0,  1'b0, 8'h00},
		'{1'b0, 24'h000000, 8'h7E, 1'b1, 6'd12, 1'b0, 8'h00},
		'{1'b1, 24'hFFFFFF, 8'h80, 1'b0, 6'd1,  1'b0, 8'h00},
		'{1'b0, 24'h000000, 8'h00, 1'b0, 6'd2,  1'b0, 8'h00},
		'{1'b0, 24'h000000, 8'hFF, 1'b1, 6'd3,  1'b0, 8'h00},
		'{1'b1, 24'h555555, 8'hC3, 1'b1, 6'd42, 1'b0, 8'h00}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [23:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tready = 1'b0;
	wire         cfg_ready;
	wire         s_tready;
	wire         m_tvalid;
	wire  [7:0]  m_tdata;
	wire         m_tuser;
	wire         m_tlast;

	logic [23:0] crc_seed_cfg = CRC24_SEED_RST;
	logic [23:0] crc_acc = CRC24_SEED_RST;
	logic [7:0]  wh_lfsr = '0;
	logic        pkt_open = 1'b0;
	air_byte_t   air_bytes_due [$];

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	logic hold_request = 1'b0;
	logic rx_hold = 1'b0;
	int mismatches = 0;
	int items_sent = 0;
	int packets_sent = 0;
	int bytes_checked = 0;
	int tails_seen = 0;

	ble_packet_crc_whiten_encoder_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] mirror8(input logic [7:0] b);
		logic [7:0] r;
		for (int k = 0; k < 8; k++) begin
			r[7-k] = b[k];
		end
		return r;
	endfunction

	function automatic logic [23:0] crc24_absorb(input logic [23:0] crc, input logic [7:0] d);
		logic [23:0] c;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			c = {c[22:0], 1'b0} ^ ((c[23] ^ d[k]) ? CRC24_FEEDBACK : 24'h000000);
		end
		return c;
	endfunction

	function automatic logic [7:0] scramble(input logic [7:0] d);
		logic [7:0] w;
		w = d;
		for (int k = 0; k < 8; k++) begin
			w[k] = w[k] ^ wh_lfsr[7];
			wh_lfsr = {wh_lfsr[6:0], 1'b0} ^ (wh_lfsr[7] ? WHITEN_STEP : 8'h00);
		end
		return w;
	endfunction

	function automatic void encode_pdu_byte(input logic [7:0] d, input logic last,
			input logic [5:0] ch, input logic pinned, input logic [7:0] pinned_out);
		air_byte_t  e;
		logic [7:0] c;
		if (!pkt_open) begin
			wh_lfsr = mirror8({2'b00, ch}) | WHITEN_ONE;
			crc_acc = crc_seed_cfg;
			pkt_open = 1'b1;
		end
		crc_acc = crc24_absorb(crc_acc, d);
		e.out_val = mirror8(scramble(d));
		if (pinned) begin
			e.out_val = pinned_out;
		end
		e.crc_flag = 1'b0;
		e.eop = 1'b0;
		air_bytes_due.push_back(e);
		if (last) begin
			for (int k = 0; k < 3; k++) begin
				c = crc_acc[23-8*k -: 8];
				e.out_val = mirror8(scramble(mirror8(c)));
				e.crc_flag = 1'b1;
				e.eop = (k == 2);
				air_bytes_due.push_back(e);
			end
			pkt_open = 1'b0;
		end
	endfunction

	task automatic log_mismatch(input string what);
		mismatches++;
		if (mismatches <= 30) begin
			$display("MISMATCH at %0t ns: %s", $time, what);
		end
	endtask

	always @(posedge clk) begin
		m_tready <= !rx_hold && ($urandom_range(99) >= rcv_idle_pct);
	end

	initial begin
		wait (hold_request);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		air_byte_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (air_bytes_due.size() == 0) begin
				log_mismatch($sformatf("unexpected item, out_byte %02h", m_tdata));
			end else begin
				e = air_bytes_due.pop_front();
				bytes_checked++;
				if (e.eop) begin
					tails_seen++;
				end
				if (m_tdata !== e.out_val) begin
					log_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, e.out_val));
				end
				if (m_tuser !== e.crc_flag) begin
					log_mismatch($sformatf("is_crc %b, want %b", m_tuser, e.crc_flag));
				end
				if (m_tlast !== e.eop) begin
					log_mismatch($sformatf("end_of_packet %b, want %b", m_tlast, e.eop));
				end
			end
		end
	end

	task automatic push_byte(input logic [7:0] d, input logic last, input logic [5:0] ch,
			input logic pinned, input logic [7:0] pinned_out);
		int gap;
		gap = 0;
		while (gap < 24 && $urandom_range(99) < snd_idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, ch, d};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		encode_pdu_byte(d, last, ch, pinned, pinned_out);
		items_sent++;
	endtask

	task automatic settle_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (air_bytes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic load_crc_seed(input logic [23:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		crc_seed_cfg = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_packet(input int len, input logic [5:0] ch);
		logic [5:0] lane;
		for (int i = 0; i < len; i++) begin
			lane = (i == 0) ? ch : 6'($urandom_range(63));
			push_byte(8'($urandom_range(255)), i == len - 1, lane, 1'b0, 8'h00);
		end
		packets_sent++;
	endtask

	task automatic run_random_phase(input int n_items);
		int goal;
		int len;
		int ch;
		goal = items_sent + n_items;
		while (items_sent < goal) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(11, 37) : $urandom_range(1, 6);
			ch = ($urandom_range(7) == 0) ? $urandom_range(40, 63) : $urandom_range(0, 39);
			send_packet(len, 6'(ch));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			if (PDU_SCRIPT[r].cfg_before) begin
				settle_idle();
				load_crc_seed(PDU_SCRIPT[r].cfg_value);
			end
			push_byte(PDU_SCRIPT[r].data, PDU_SCRIPT[r].last, PDU_SCRIPT[r].chan,
				PDU_SCRIPT[r].pinned, PDU_SCRIPT[r].pinned_out);
			if (PDU_SCRIPT[r].last) begin
				packets_sent++;
			end
		end

		settle_idle();
		load_crc_seed(24'($urandom_range(24'hFFFFFF)));
		snd_idle_pct = 14;
		rcv_idle_pct = 86;
		run_random_phase(PHASE_ITEMS);

		settle_idle();
		load_crc_seed(24'($urandom_range(24'hFFFFFF)));
		snd_idle_pct = 86;
		rcv_idle_pct = 14;
		run_random_phase(PHASE_ITEMS);

		settle_idle();
		load_crc_seed(24'hFFFFFF);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_request = 1'b1;
		run_random_phase(PHASE_ITEMS);

		settle_idle();
		repeat (10) @(posedge clk);
		$display("Checked %0d output bytes from %0d PDU bytes in %0d packets, %0d CRC tails.",
			bytes_checked, items_sent, packets_sent, tails_seen);
		$display("Seeds at reset value, all zeros, all ones and random; channels 0 to 63; "
			, "long output hold.");
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d items still expected.", air_bytes_due.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
